@@ rtl/core/gha_pkg.sv @@
// Package for the generational handle allocator: sizes, codes, memory word types.
package gha_pkg;

    localparam int SLOTS        = 1024;
    localparam int VERSION_BITS = 16;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;

    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [VERSION_BITS-1:0] FIRST_VERSION = VERSION_BITS'(1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                    live;
        logic [VERSION_BITS-1:0] version;
    } t_slot_word;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic [VERSION_BITS-1:0] version;
    } t_free_entry;

endpackage

@@ rtl/core/generational_handle_allocator.sv @@
// Generational handle allocator: slot memory, LIFO free stack memory, request sequencer.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------------
//  request | i_in_valid  | o_in_stall  | i_kind, i_handle_index, i_handle_version
//  result  | o_out_valid | i_out_stall | o_out_index, o_out_version, o_status
//
// In each transaction the accept edge reads the slot memory and the top of the free
// stack; the execute state then evaluates and writes both memories back.
// The output register lets the next transaction be accepted while a result waits.
// A result stalled downstream holds the sequencer in its execute cycle.
// Reset clears the state, the counters and the output valid flag only; slot entries
// above the high-water mark are never consulted, so the memories need no clearing pass.
module generational_handle_allocator
    import gha_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic [IDX_W-1:0]        i_handle_index,
    input  logic [VERSION_BITS-1:0] i_handle_version,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [IDX_W-1:0]        o_out_index,
    output logic [VERSION_BITS-1:0] o_out_version,
    output logic [STATUS_W-1:0]     o_status
);

    t_slot_word  slot_mem [SLOTS];
    t_free_entry free_mem [SLOTS];

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_free_count, n_free_count;
    logic [CNT_W-1:0]        r_high_water, n_high_water;
    logic [KIND_W-1:0]       r_kind;
    logic [IDX_W-1:0]        r_idx;
    logic [VERSION_BITS-1:0] r_ver;
    t_slot_word              r_slot_rd;
    t_free_entry             r_free_rd;

    logic                    r_out_valid, n_out_valid;
    logic [IDX_W-1:0]        r_out_index, n_out_index;
    logic [VERSION_BITS-1:0] r_out_version, n_out_version;
    logic [STATUS_W-1:0]     r_status, n_status;

    logic        in_accept;
    logic        out_free;
    logic        exec_fire;
    logic        handle_ok;
    logic        slot_we;
    logic [IDX_W-1:0] slot_waddr;
    t_slot_word  slot_wdata;
    logic        free_we;
    t_free_entry free_wdata;
    logic [VERSION_BITS-1:0] bumped_ver;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        exec_fire  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_EXEC: exec_fire  = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign handle_ok  = ({1'b0, r_idx} < r_high_water) && r_slot_rd.live
                        && (r_slot_rd.version == r_ver);
    assign bumped_ver = r_ver + FIRST_VERSION;

    // evaluate one transaction
    always_comb begin
        n_free_count  = r_free_count;
        n_high_water  = r_high_water;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_index   = r_out_index;
        n_out_version = r_out_version;
        n_status      = r_status;
        slot_we       = 1'b0;
        slot_waddr    = r_idx;
        slot_wdata    = '{live: 1'b0, version: bumped_ver};
        free_we       = 1'b0;
        free_wdata    = '{index: r_idx, version: bumped_ver};
        if (exec_fire) begin
            n_out_valid   = 1'b1;
            n_out_index   = r_idx;
            n_out_version = r_ver;
            n_status      = STATUS_OK;
            case (r_kind)
                KIND_CREATE: begin
                    if (r_free_count != '0) begin
                        n_free_count  = r_free_count - CNT_W'(1);
                        n_out_index   = r_free_rd.index;
                        n_out_version = r_free_rd.version;
                        slot_we       = 1'b1;
                        slot_waddr    = r_free_rd.index;
                        slot_wdata    = '{live: 1'b1, version: r_free_rd.version};
                    end else if (r_high_water < SLOTS_CNT) begin
                        n_high_water  = r_high_water + CNT_W'(1);
                        n_out_index   = r_high_water[IDX_W-1:0];
                        n_out_version = FIRST_VERSION;
                        slot_we       = 1'b1;
                        slot_waddr    = r_high_water[IDX_W-1:0];
                        slot_wdata    = '{live: 1'b1, version: FIRST_VERSION};
                    end else begin
                        n_out_index   = '0;
                        n_out_version = '0;
                        n_status      = STATUS_FULL;
                    end
                end
                KIND_DESTROY: begin
                    if (handle_ok) begin
                        slot_we = 1'b1;
                        if (r_free_count < SLOTS_CNT) begin
                            free_we      = 1'b1;
                            n_free_count = r_free_count + CNT_W'(1);
                        end
                    end else begin
                        n_status = STATUS_INVALID;
                    end
                end
                default: begin
                    if (!handle_ok) n_status = STATUS_INVALID;
                end
            endcase
        end
    end

    // slot memory: live bit and current version per slot
    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
        if (in_accept) r_slot_rd <= slot_mem[i_handle_index];
    end

    // free stack memory: freed slot and the version it comes back with
    always_ff @(posedge i_clk) begin
        if (free_we) free_mem[r_free_count[IDX_W-1:0]] <= free_wdata;
        if (in_accept) r_free_rd <= free_mem[r_free_count[IDX_W-1:0] - IDX_W'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_count <= '0;
            r_high_water <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_high_water <= n_high_water;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind <= i_kind;
            r_idx  <= i_handle_index;
            r_ver  <= i_handle_version;
        end
        r_out_index   <= n_out_index;
        r_out_version <= n_out_version;
        r_status      <= n_status;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_index   = r_out_index;
    assign o_out_version = r_out_version;
    assign o_status      = r_status;

    a_free_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_high_water)
        else $error("free count exceeds high-water mark");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= SLOTS_CNT)
        else $error("high-water mark beyond slot count");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EXEC))
        else $error("accepted transaction not executed");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_EXEC))
        else $error("result without execute cycle");

endmodule
